// ----- design/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define PHS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, checked outside of reset.
`define PHS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ----- design/phs_pkg.sv -----
`default_nettype none

package phs_pkg;

  localparam logic FUNC_MARK  = 1'b0;
  localparam logic FUNC_CHECK = 1'b1;

  localparam logic [63:0] HASH_MULT = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [31:0] HASH_LO   = HASH_MULT[31:0];
  localparam logic [31:0] HASH_HI   = HASH_MULT[63:32];

  localparam logic [1:0] MUL_STEP_KH = 2'd1;
  localparam logic [1:0] MUL_STEP_MH = 2'd2;
  localparam logic [1:0] MUL_LAST    = 2'd3;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    MS_INSERTED = 2'd0,
    MS_PRESENT  = 2'd1,
    MS_FULL     = 2'd2,
    MS_NONE     = 2'd3
  } phs_status_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_PUSH
  } phs_front_state_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_PROBE
  } phs_back_state_t;

  typedef struct packed {
    logic        func;
    logic [63:0] key;
    logic [63:0] mixed;
  } phs_item_t;

endpackage

`default_nettype wire

// ----- design/phs_ram.sv -----
`default_nettype none

module phs_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/phs_front.sv -----
`default_nettype none

`include "assert_macros.svh"

module phs_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_func,
  input  logic [31:0]         in_table_id,
  input  logic [31:0]         in_block_number,
  input  logic                hold,
  input  logic                q_full,
  output logic                push,
  output phs_pkg::phs_item_t  push_item
);

  phs_pkg::phs_front_state_t state_r, state_nxt;
  logic [1:0]  step_r;
  logic        func_r;
  logic [63:0] key_r;
  logic [63:0] prod_r;
  logic [63:0] acc_r;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] prod_nxt;
  logic        accept;

  assign busy   = (state_r != phs_pkg::F_IDLE) || hold;
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      phs_pkg::F_IDLE: begin
        if (accept) state_nxt = phs_pkg::F_MUL;
      end
      phs_pkg::F_MUL: begin
        if (step_r == phs_pkg::MUL_LAST) state_nxt = phs_pkg::F_PUSH;
      end
      phs_pkg::F_PUSH: begin
        if (!q_full) state_nxt = phs_pkg::F_IDLE;
      end
      default: state_nxt = phs_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    op_a            = (step_r == phs_pkg::MUL_STEP_KH) ? key_r[63:32] : key_r[31:0];
    op_b            = (step_r == phs_pkg::MUL_STEP_MH) ? phs_pkg::HASH_HI : phs_pkg::HASH_LO;
    prod_nxt        = {32'd0, op_a} * {32'd0, op_b};
    push            = (state_r == phs_pkg::F_PUSH) && !q_full;
    push_item.func  = func_r;
    push_item.key   = key_r;
    push_item.mixed = acc_r ^ (acc_r >> 32);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= phs_pkg::F_IDLE;
      step_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        step_r <= 2'd0;
      end else if (state_r == phs_pkg::F_MUL) begin
        step_r <= step_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func;
      key_r  <= {in_table_id, in_block_number};
    end
    if (state_r == phs_pkg::F_MUL) begin
      prod_r <= prod_nxt;
      if (step_r == phs_pkg::MUL_STEP_KH) begin
        acc_r <= prod_r;
      end else if (step_r != 2'd0) begin
        acc_r[63:32] <= acc_r[63:32] + prod_r[31:0];
      end
    end
  end

  `PHS_ASSERT_NXT(a_accept_busy, clk, rst_n, accept, busy)

endmodule

`default_nettype wire

// ----- design/phs_fifo.sv -----
`default_nettype none

`include "assert_macros.svh"

module phs_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  phs_pkg::phs_item_t push_item,
  output logic               full,
  output logic               valid,
  output phs_pkg::phs_item_t head,
  input  logic               pop
);

  localparam int PtrW = (phs_pkg::QUEUE_DEPTH > 1) ? $clog2(phs_pkg::QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(phs_pkg::QUEUE_DEPTH + 1);

  phs_pkg::phs_item_t entries_r [phs_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] count_r;

  assign full  = (count_r == CntW'(phs_pkg::QUEUE_DEPTH));
  assign valid = (count_r != '0);
  assign head  = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(phs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(phs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

  `PHS_ASSERT_IMP(a_no_overflow, clk, rst_n, push, !full)
  `PHS_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, valid)

endmodule

`default_nettype wire

// ----- design/phs_back.sv -----
`default_nettype none

`include "assert_macros.svh"

module phs_back #(
  parameter int PARTITIONS          = 8,
  parameter int SLOTS_PER_PARTITION = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  phs_pkg::phs_item_t q_head,
  output logic               pop,
  output logic               clearing,
  output logic               out_valid,
  output logic               out_dirty,
  output logic [1:0]         out_mark_status
);

  localparam int PW     = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int PShift = $clog2(PARTITIONS);
  localparam int SW     = $clog2(SLOTS_PER_PARTITION);
  localparam int Depth  = PARTITIONS * SLOTS_PER_PARTITION;
  localparam int AW     = $clog2(Depth);
  localparam int Limit  = (SLOTS_PER_PARTITION * 3) / 4;

  phs_pkg::phs_back_state_t state_r, state_nxt;
  logic [AW-1:0]  clr_addr_r;
  logic           func_r;
  logic [63:0]    key_r;
  logic [PW-1:0]  part_r;
  logic [SW-1:0]  slot_r;
  logic [SW-1:0]  probe_r;
  logic [SW-1:0]  cnt_r [PARTITIONS];
  logic [PARTITIONS-1:0] full_r;
  logic           out_valid_r, out_valid_nxt;
  logic           out_dirty_r, out_dirty_nxt;
  phs_pkg::phs_status_t out_status_r, out_status_nxt;

  logic           we;
  logic [AW-1:0]  waddr;
  logic [63:0]    wdata;
  logic           re;
  logic [AW-1:0]  raddr;
  logic [63:0]    rdata;

  logic [PW-1:0]  head_part;
  logic [SW-1:0]  head_slot;
  logic           is_check;
  logic           part_full;
  logic           hit;
  logic           empty;
  logic           last;
  logic           probe_done;
  logic           clr_last;
  logic           set_full;
  logic           inc_cnt;
  logic           advance;

  assign head_part  = q_head.mixed[PW-1:0] & PW'(PARTITIONS - 1);
  assign head_slot  = SW'(q_head.mixed >> PShift);
  assign is_check   = (func_r == phs_pkg::FUNC_CHECK);
  assign part_full  = full_r[part_r];
  assign hit        = (rdata == key_r);
  assign empty      = (rdata == 64'd0);
  assign last       = (probe_r == SW'(SLOTS_PER_PARTITION - 1));
  assign probe_done = part_full || hit || empty || last;
  assign clr_last   = (clr_addr_r == AW'(Depth - 1));
  assign clearing   = (state_r == phs_pkg::B_CLEAR);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      phs_pkg::B_CLEAR: begin
        if (clr_last) state_nxt = phs_pkg::B_IDLE;
      end
      phs_pkg::B_IDLE: begin
        if (q_valid) state_nxt = phs_pkg::B_PROBE;
      end
      phs_pkg::B_PROBE: begin
        if (probe_done) state_nxt = phs_pkg::B_IDLE;
      end
      default: state_nxt = phs_pkg::B_CLEAR;
    endcase
  end

  always_comb begin
    we             = 1'b0;
    waddr          = AW'({part_r, slot_r});
    wdata          = key_r;
    re             = 1'b0;
    raddr          = AW'({part_r, SW'(slot_r + 1'b1)});
    pop            = 1'b0;
    out_valid_nxt  = 1'b0;
    out_dirty_nxt  = 1'b0;
    out_status_nxt = phs_pkg::MS_NONE;
    set_full       = 1'b0;
    inc_cnt        = 1'b0;
    advance        = 1'b0;
    unique case (state_r)
      phs_pkg::B_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr_r;
        wdata = 64'd0;
      end
      phs_pkg::B_IDLE: begin
        if (q_valid) begin
          pop   = 1'b1;
          re    = 1'b1;
          raddr = AW'({head_part, head_slot});
        end
      end
      phs_pkg::B_PROBE: begin
        priority if (part_full) begin
          out_valid_nxt  = 1'b1;
          out_dirty_nxt  = is_check;
          out_status_nxt = is_check ? phs_pkg::MS_NONE : phs_pkg::MS_FULL;
        end else if (hit) begin
          out_valid_nxt  = 1'b1;
          out_dirty_nxt  = is_check;
          out_status_nxt = is_check ? phs_pkg::MS_NONE : phs_pkg::MS_PRESENT;
        end else if (empty) begin
          out_valid_nxt = 1'b1;
          if (is_check) begin
            out_status_nxt = phs_pkg::MS_NONE;
          end else if (cnt_r[part_r] >= SW'(Limit)) begin
            set_full       = 1'b1;
            out_status_nxt = phs_pkg::MS_FULL;
          end else begin
            we             = 1'b1;
            inc_cnt        = 1'b1;
            out_status_nxt = phs_pkg::MS_INSERTED;
          end
        end else if (last) begin
          out_valid_nxt  = 1'b1;
          out_dirty_nxt  = is_check;
          set_full       = !is_check;
          out_status_nxt = is_check ? phs_pkg::MS_NONE : phs_pkg::MS_FULL;
        end else begin
          re      = 1'b1;
          advance = 1'b1;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= phs_pkg::B_CLEAR;
      clr_addr_r  <= '0;
      full_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < PARTITIONS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (clearing) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (set_full) begin
        full_r[part_r] <= 1'b1;
      end
      if (inc_cnt) begin
        cnt_r[part_r] <= cnt_r[part_r] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_dirty_r  <= out_dirty_nxt;
    out_status_r <= out_status_nxt;
    if (pop) begin
      func_r  <= q_head.func;
      key_r   <= q_head.key;
      part_r  <= head_part;
      slot_r  <= head_slot;
      probe_r <= '0;
    end else if (advance) begin
      slot_r  <= slot_r + 1'b1;
      probe_r <= probe_r + 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_dirty       = out_dirty_r;
  assign out_mark_status = out_status_r;

  phs_ram #(
    .Width (64),
    .Depth (Depth)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  `PHS_ASSERT_NXT(a_single_strobe, clk, rst_n, out_valid_r, !out_valid_r)
  `PHS_ASSERT_IMP(a_insert_on_mark, clk, rst_n, (state_r == phs_pkg::B_PROBE) && we, func_r == phs_pkg::FUNC_MARK)
  `PHS_ASSERT_IMP(a_count_limit, clk, rst_n, state_r == phs_pkg::B_PROBE, cnt_r[part_r] <= SW'(Limit))

endmodule

`default_nettype wire

// ----- design/partitioned_hash_set_mark_check_top.sv -----
`default_nettype none

// Grow-only set of 64-bit keys {in_table_id, in_block_number} kept in PARTITIONS
// open-addressed tables with linear probing. After reset the block clears its slot
// memory, one slot per cycle, all PARTITIONS*SLOTS_PER_PARTITION (8192 with the
// defaults) of them, and holds busy high meanwhile. A transaction is taken when
// start is high and busy is low; the hash front end then runs it through its
// shared 32x32 multiplier and takes no next one until it has pushed the result
// into a two-entry queue that decouples it from the probe engine. The probe
// engine pops a key and issues its first slot memory read while idle, then one
// further read per probe, and pops no new key until that key's probe has ended.
// Each result is shown for exactly one cycle with out_valid; the receiver must
// take it then, as the block cannot be stalled from the output side.

module partitioned_hash_set_mark_check_top #(
  parameter int PARTITIONS          = 8,
  parameter int SLOTS_PER_PARTITION = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [31:0] in_table_id,
  input  logic [31:0] in_block_number,
  output logic        out_valid,
  output logic        out_dirty,
  output logic [1:0]  out_mark_status
);

  logic               push;
  phs_pkg::phs_item_t push_item;
  logic               q_full;
  logic               q_valid;
  phs_pkg::phs_item_t q_head;
  logic               pop;
  logic               clearing;

  phs_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_table_id     (in_table_id),
    .in_block_number (in_block_number),
    .hold            (clearing),
    .q_full          (q_full),
    .push            (push),
    .push_item       (push_item)
  );

  phs_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head),
    .pop       (pop)
  );

  phs_back #(
    .PARTITIONS          (PARTITIONS),
    .SLOTS_PER_PARTITION (SLOTS_PER_PARTITION)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_head          (q_head),
    .pop             (pop),
    .clearing        (clearing),
    .out_valid       (out_valid),
    .out_dirty       (out_dirty),
    .out_mark_status (out_mark_status)
  );

endmodule

`default_nettype wire

// ----- test/phs_membership_check.sv -----
module phs_membership_check
  import phs_pkg::*;
#(
  parameter int PARTITIONS          = 8,
  parameter int SLOTS_PER_PARTITION = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_func,
  input  logic [31:0] in_table_id,
  input  logic [31:0] in_block_number,
  input  logic        out_valid,
  input  logic        out_dirty,
  input  logic [1:0]  out_mark_status,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PART_BITS  = $clog2(PARTITIONS);
  localparam int SLOT_MASK  = SLOTS_PER_PARTITION - 1;
  localparam int LOAD_LIMIT = (SLOTS_PER_PARTITION * 3) / 4;

  typedef struct packed {
    logic        dirty;
    phs_status_t status;
  } set_answer_t;

  logic [63:0]  stored_keys [PARTITIONS * SLOTS_PER_PARTITION];
  int unsigned  part_count  [PARTITIONS];
  bit           part_full   [PARTITIONS];
  set_answer_t  answers_due [$];
  int           errs = 0;

  function automatic set_answer_t mark_or_check(input logic func, input logic [63:0] key);
    logic [63:0] prod;
    logic [63:0] mixed;
    logic [63:0] cur;
    int unsigned part;
    int unsigned slot;
    int unsigned base;
    bit          done;
    set_answer_t ans;
    prod  = key * HASH_MULT;
    mixed = prod ^ (prod >> 32);
    part  = int'(mixed & 64'(PARTITIONS - 1));
    slot  = int'((mixed >> PART_BITS) & 64'(SLOT_MASK));
    base  = part * SLOTS_PER_PARTITION;
    done  = 1'b0;
    if (func == FUNC_CHECK) begin
      ans.dirty  = 1'b1;
      ans.status = MS_NONE;
      if (!part_full[part]) begin
        for (int probe = 0; probe < SLOTS_PER_PARTITION && !done; probe++) begin
          cur = stored_keys[base + slot];
          if (cur == key) begin
            done = 1'b1;
          end else if (cur == '0) begin
            ans.dirty = 1'b0;
            done      = 1'b1;
          end else begin
            slot = (slot + 1) & SLOT_MASK;
          end
        end
      end
      return ans;
    end
    ans.dirty  = 1'b0;
    ans.status = MS_FULL;
    if (part_full[part]) return ans;
    for (int probe = 0; probe < SLOTS_PER_PARTITION && !done; probe++) begin
      cur = stored_keys[base + slot];
      if (cur == key) begin
        ans.status = MS_PRESENT;
        done       = 1'b1;
      end else if (cur == '0) begin
        if (part_count[part] >= LOAD_LIMIT) begin
          part_full[part] = 1'b1;
        end else begin
          stored_keys[base + slot] = key;
          part_count[part]++;
          ans.status = MS_INSERTED;
        end
        done = 1'b1;
      end else begin
        slot = (slot + 1) & SLOT_MASK;
      end
    end
    if (!done) part_full[part] = 1'b1;
    return ans;
  endfunction

  always @(posedge clk) begin
    set_answer_t want;
    if (!rst_n) begin
      foreach (stored_keys[i]) stored_keys[i] = '0;
      foreach (part_count[i]) part_count[i] = 0;
      foreach (part_full[i]) part_full[i] = 1'b0;
      answers_due.delete();
    end else begin
      if (out_valid) begin
        if (answers_due.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: result with no transaction outstanding: dirty %0b status %0d",
                     $time, out_dirty, out_mark_status);
        end else begin
          want = answers_due.pop_front();
          if (out_dirty !== want.dirty || out_mark_status !== want.status) begin
            errs++;
            if (errs <= 10)
              $display("%0t: mismatch: expected dirty %0b status %0d, got dirty %0b status %0d",
                       $time, want.dirty, want.status, out_dirty, out_mark_status);
          end
        end
      end
      if (start && !busy)
        answers_due.push_back(mark_or_check(in_func, {in_table_id, in_block_number}));
    end
    mismatches  <= errs;
    outstanding <= answers_due.size();
  end

endmodule

// ----- test/partitioned_hash_set_mark_check_top_tb.sv -----
module partitioned_hash_set_mark_check_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import phs_pkg::*;

  localparam int PARTITIONS          = 8;
  localparam int SLOTS_PER_PARTITION = 1024;
  localparam int LOAD_LIMIT          = (SLOTS_PER_PARTITION * 3) / 4;
  localparam int HOME_BITS           = $clog2(PARTITIONS) + $clog2(SLOTS_PER_PARTITION);

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        start           = 1'b0;
  logic        in_func         = FUNC_MARK;
  logic [31:0] in_table_id     = '0;
  logic [31:0] in_block_number = '0;
  logic        busy;
  logic        out_valid;
  logic        out_dirty;
  logic [1:0]  out_mark_status;
  int          mismatches;
  int          outstanding;

  int          idle_pct;
  bit          marked [bit [63:0]];
  logic [63:0] marked_list [$];
  int unsigned home_fill [PARTITIONS];
  logic [63:0] anchor;
  logic [63:0] twin;
  logic [63:0] third;

  always #5 clk = ~clk;

  partitioned_hash_set_mark_check_top #(
    .PARTITIONS          (PARTITIONS),
    .SLOTS_PER_PARTITION (SLOTS_PER_PARTITION)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_table_id     (in_table_id),
    .in_block_number (in_block_number),
    .out_valid       (out_valid),
    .out_dirty       (out_dirty),
    .out_mark_status (out_mark_status)
  );

  phs_membership_check #(
    .PARTITIONS          (PARTITIONS),
    .SLOTS_PER_PARTITION (SLOTS_PER_PARTITION)
  ) membership (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_table_id     (in_table_id),
    .in_block_number (in_block_number),
    .out_valid       (out_valid),
    .out_dirty       (out_dirty),
    .out_mark_status (out_mark_status),
    .mismatches      (mismatches),
    .outstanding     (outstanding)
  );

  // Home position of a key: partition in the low bits, first slot above them.
  function automatic int unsigned home_of(input logic [63:0] key);
    logic [63:0] prod;
    logic [63:0] mixed;
    prod  = key * HASH_MULT;
    mixed = prod ^ (prod >> 32);
    return int'(mixed[HOME_BITS-1:0]);
  endfunction

  function automatic logic [63:0] fresh_key(input int part);
    logic [63:0] k;
    do begin
      k = {$urandom, $urandom};
    end while (k == '0 || marked.exists(k) ||
               (part >= 0 && int'(home_of(k) % PARTITIONS) != part));
    return k;
  endfunction

  function automatic logic [63:0] slot_twin(input logic [63:0] key);
    logic [63:0] k;
    do begin
      k = fresh_key(-1);
    end while (home_of(k) != home_of(key) || k == key);
    return k;
  endfunction

  function automatic logic [63:0] known_key();
    return marked_list[$urandom_range(marked_list.size() - 1)];
  endfunction

  task automatic issue(input logic func, input logic [63:0] key);
    int unsigned part;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    in_func         <= func;
    in_table_id     <= key[63:32];
    in_block_number <= key[31:0];
    do @(posedge clk); while (busy);
    part = home_of(key) % PARTITIONS;
    if (func == FUNC_MARK && key != '0 && !marked.exists(key) &&
        home_fill[part] < LOAD_LIMIT) begin
      marked[key] = 1'b1;
      marked_list.push_back(key);
      home_fill[part]++;
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic random_mix(input int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 40) issue(FUNC_MARK, fresh_key(-1));
      else if (pick < 65) issue(FUNC_CHECK, known_key());
      else if (pick < 80) issue(FUNC_CHECK, fresh_key(-1));
      else if (pick < 88) issue(FUNC_MARK, known_key());
      else if (pick < 95) issue(1'($urandom_range(1)), fresh_key(0));
      else issue(1'($urandom_range(1)), '0);
    end
  endtask

  initial begin
    #20ms;
    $display("partitioned_hash_set_mark_check_top test failed");
    $finish;
  end

  initial begin
    idle_pct = 32;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    issue(FUNC_MARK, '0);
    issue(FUNC_CHECK, '0);
    issue(FUNC_CHECK, '1);
    issue(FUNC_MARK, '1);
    issue(FUNC_MARK, '1);
    issue(FUNC_CHECK, '1);
    issue(FUNC_MARK, {32'hFFFF_FFFF, 32'h0000_0000});
    issue(FUNC_MARK, {32'h0000_0000, 32'hFFFF_FFFF});
    issue(FUNC_CHECK, {32'hFFFF_FFFF, 32'h0000_0000});
    issue(FUNC_CHECK, {32'h0000_0000, 32'h0000_0001});
    // Keys sharing one home slot force probing past occupied entries.
    anchor = fresh_key(0);
    twin   = slot_twin(anchor);
    third  = slot_twin(anchor);
    issue(FUNC_MARK, anchor);
    issue(FUNC_CHECK, twin);
    issue(FUNC_MARK, twin);
    issue(FUNC_CHECK, twin);
    issue(FUNC_CHECK, third);
    issue(FUNC_MARK, twin);
    random_mix(180);

    // Fill one partition up to the load ceiling.
    idle_pct = 58;
    while (home_fill[0] < LOAD_LIMIT - 1) begin
      if ($urandom_range(11) == 0) issue(FUNC_CHECK, known_key());
      else issue(FUNC_MARK, fresh_key(0));
    end
    drain();
    issue(FUNC_MARK, fresh_key(0));
    issue(FUNC_MARK, anchor);
    issue(FUNC_CHECK, fresh_key(0));
    issue(FUNC_MARK, fresh_key(0));
    issue(FUNC_MARK, anchor);
    issue(FUNC_CHECK, anchor);
    issue(FUNC_CHECK, fresh_key(0));
    issue(FUNC_MARK, '0);
    issue(FUNC_CHECK, '0);

    idle_pct = 0;
    random_mix(120);
    drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("partitioned_hash_set_mark_check_top test passed");
    end else begin
      $display("partitioned_hash_set_mark_check_top test failed");
    end
    $finish;
  end

endmodule
